[src/stc_pkg.sv]
package stc_pkg;

  // Field widths fixed by the stream format
  localparam int SAMPLE_W   = 16;
  localparam int LIMIT_W    = 15;
  localparam int SLOT_W     = 6;
  localparam int FILL_W     = 7;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - FILL_W - SLOT_W - SAMPLE_W;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] RST_LEVEL      = 16'sd1000;
  localparam logic [SAMPLE_W-1:0]        RST_DECIMATION = 16'd1000;
  localparam logic [LIMIT_W-1:0]         RST_LIMIT      = 15'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT   = 2'd2;

  // Input kinds carried in tuser
  localparam logic OP_FAST = 1'b0;
  localparam logic OP_SLOW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST,
    ST_DRAIN
  } stc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic fast_go;   // fast tick accepted
    logic slow_go;   // slow tick accepted
    logic rd_en;     // issue a store read
    logic ld_out;    // move read stage into output register
    logic finish;    // burst fully handed to output register
  } stc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic burst_hit; // a slow tick now would start a redraw burst
  } stc_sts_t;

endpackage

[src/scope_trigger_capture_unit.sv]
// Oscilloscope trigger and capture unit.
// Input stream: in_tuser[0] is the tick kind (0 fast tick with sample, 1 slow
// tick), in_tdata[15:0] the signed sample. Fast ticks are decimated, arm on a
// negative sample, trigger when a sample exceeds the trigger level and fill a
// CAPTURE_DEPTH-entry store. Slow ticks run the redraw and forced-retrigger
// countdowns.
// Output stream: one transaction per store slot during a redraw burst, tlast
// on the final slot.
// Config port: cfg_we writes register cfg_index (0 trigger level, 1
// decimation, 2 clamp limit); other indexes are ignored.
// Throughput: one input transaction per cycle outside a redraw burst. A slow
// tick that starts a redraw holds in_tready low while the store is read out
// one slot per cycle (while out_tready allows); out_tvalid rises when slot 0
// reaches the output register. The single read port sets the burst length.
// A stalled receiver stalls the burst; the last result sits in the output
// register while new input transactions are already taken.
// Reset: registers return to 1000, capture waits for a negative sample, the
// store reads as zero through per-entry valid bits (no clearing pass).
module scope_trigger_capture_unit #(
  parameter int CAPTURE_DEPTH    = 64,
  parameter int REDRAW_PERIOD    = 10,
  parameter int RETRIGGER_PERIOD = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [stc_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] sample_in
  input  logic [0:0]                        in_tuser,   // [0] opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] clamped_value, [21:16] slot_index, [28:22] filled_count
  output logic [stc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,  // last_of_burst
  input  logic                              cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import stc_pkg::*;

  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

  stc_cmd_t                   cmd;
  stc_sts_t                   sts;
  logic [AW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] clamped_value;
  logic [SLOT_W-1:0]          slot_index;
  logic [FILL_W-1:0]          filled_count;

  stc_ctrl #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .opcode    (in_tuser[0]),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  stc_dp #(
    .CAPTURE_DEPTH   (CAPTURE_DEPTH),
    .REDRAW_PERIOD   (REDRAW_PERIOD),
    .RETRIGGER_PERIOD(RETRIGGER_PERIOD),
    .AW              (AW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .sample       (in_tdata[SAMPLE_W-1:0]),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .sts          (sts),
    .clamped_value(clamped_value),
    .slot_index   (slot_index),
    .filled_count (filled_count),
    .last_of_burst(out_tlast)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, filled_count, slot_index, clamped_value};

  // A slow tick that starts a redraw blocks the input on the next cycle
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == OP_SLOW && sts.burst_hit) |=> !in_tready)
    else $error("input not held off after redraw start");

  // The final value of a burst carries the last slot
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (slot_index == SLOT_W'(CAPTURE_DEPTH - 1)))
    else $error("tlast on wrong slot");

  // A burst only happens with a nonempty capture
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (filled_count != '0 && filled_count <= FILL_W'(CAPTURE_DEPTH)))
    else $error("filled count out of range");

endmodule

[src/stc_ctrl.sv]
module stc_ctrl #(
  parameter int CAPTURE_DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             opcode,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  stc_pkg::stc_sts_t sts,
  output stc_pkg::stc_cmd_t cmd,
  output logic [AW-1:0]    rd_addr
);
  import stc_pkg::*;

  stc_state_t    state_r, state_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic          move;
  logic          issue;
  logic          accept;

  // State and pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    in_tready  = 1'b0;
    issue      = 1'b0;
    accept     = 1'b0;
    cmd        = '0;
    move       = rd_vld_r && (!out_vld_r || out_tready);

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (accept && opcode == OP_SLOW) begin
          cmd.slow_go = 1'b1;
          if (sts.burst_hit) begin
            state_nxt  = ST_BURST;
            rd_idx_nxt = '0;
          end
        end else if (accept) begin
          cmd.fast_go = 1'b1;
        end
      end
      ST_BURST: begin
        issue = !rd_vld_r || move;
        if (issue) begin
          if (rd_idx_r == AW'(CAPTURE_DEPTH - 1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    cmd.rd_en  = issue;
    cmd.ld_out = move;

    rd_vld_nxt = issue ? 1'b1 : (move ? 1'b0 : rd_vld_r);
    if (move) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign rd_addr    = rd_idx_r;
  assign out_tvalid = out_vld_r;

endmodule

[src/stc_dp.sv]
module stc_dp #(
  parameter int CAPTURE_DEPTH    = 64,
  parameter int REDRAW_PERIOD    = 10,
  parameter int RETRIGGER_PERIOD = 10,
  parameter int AW = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic signed [stc_pkg::SAMPLE_W-1:0]  sample,
  input  stc_pkg::stc_cmd_t                    cmd,
  input  logic [AW-1:0]                        rd_addr,
  output stc_pkg::stc_sts_t                    sts,
  output logic signed [stc_pkg::SAMPLE_W-1:0]  clamped_value,
  output logic [stc_pkg::SLOT_W-1:0]           slot_index,
  output logic [stc_pkg::FILL_W-1:0]           filled_count,
  output logic                                 last_of_burst
);
  import stc_pkg::*;

  localparam int PW = $clog2(CAPTURE_DEPTH + 1);

  // Configuration registers
  logic signed [SAMPLE_W-1:0] level_r;
  logic [SAMPLE_W-1:0]        decim_r;
  logic [LIMIT_W-1:0]         limit_r;

  // Capture state: wait_r means waiting for a negative sample
  logic                wait_r, wait_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [SAMPLE_W-1:0] dec_r, dec_nxt;
  logic [CNT_W-1:0]    red_r, red_nxt;
  logic [CNT_W-1:0]    ret_r, ret_nxt;
  logic                pend_r, pend_nxt;
  logic [FILL_W-1:0]   filled_r, filled_nxt;

  // Sample store with per-entry valid bits (invalid reads as zero)
  logic signed [SAMPLE_W-1:0] mem [CAPTURE_DEPTH];
  logic [CAPTURE_DEPTH-1:0]   vld_r;
  logic                       we;
  logic [AW-1:0]              wa;
  logic signed [SAMPLE_W-1:0] wd;

  // Read stage and output register
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic                       rbit_r;
  logic [AW-1:0]              rslot_r;
  logic                       rlast_r;
  logic signed [SAMPLE_W-1:0] out_val_r;
  logic [AW-1:0]              out_slot_r;
  logic                       out_last_r;
  logic [FILL_W-1:0]          out_fill_r;
  logic signed [SAMPLE_W-1:0] clamp_val;

  logic full;
  logic positive;

  assign full          = !wait_r && (pos_r == PW'(CAPTURE_DEPTH));
  assign positive      = !wait_r && (pos_r != '0);
  assign sts.burst_hit = positive && (red_r == '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= RST_LEVEL;
      decim_r <= RST_DECIMATION;
      limit_r <= RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_LEVEL: level_r <= cfg_wdata;
        REG_DECIMATION:    decim_r <= cfg_wdata;
        REG_CLAMP_LIMIT:   limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= 1'b1;
      pos_r  <= '0;
      dec_r  <= RST_DECIMATION;
      red_r  <= CNT_W'(REDRAW_PERIOD);
      ret_r  <= CNT_W'(RETRIGGER_PERIOD);
      pend_r <= 1'b0;
    end else begin
      wait_r <= wait_nxt;
      pos_r  <= pos_nxt;
      dec_r  <= dec_nxt;
      red_r  <= red_nxt;
      ret_r  <= ret_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    filled_r <= filled_nxt;
  end

  // Tick processing and store write port
  always_comb begin
    logic          wait_t;
    logic [PW-1:0] pos_t;
    wait_nxt   = wait_r;
    pos_nxt    = pos_r;
    dec_nxt    = dec_r;
    red_nxt    = red_r;
    ret_nxt    = ret_r;
    pend_nxt   = pend_r;
    filled_nxt = filled_r;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    wait_t     = wait_r;
    pos_t      = pos_r;

    // fast tick: decimate, arm, trigger, store
    if (cmd.fast_go && !full) begin
      if (dec_r != '0) begin
        dec_nxt = dec_r - 1'b1;
      end else begin
        dec_nxt = decim_r;
        if (wait_r) begin
          if (sample < 0) begin
            wait_nxt = 1'b0;
            pos_nxt  = '0;
          end
        end else if (pos_r == '0) begin
          if (sample > level_r) begin
            we      = 1'b1;
            wd      = sample;
            pos_nxt = PW'(1);
          end
        end else begin
          we      = 1'b1;
          wa      = pos_r[AW-1:0];
          wd      = sample;
          pos_nxt = pos_r + 1'b1;
        end
      end
    end

    // slow tick: redraw countdown, then forced retrigger
    if (cmd.slow_go) begin
      if (positive) begin
        if (red_r == '0) begin
          red_nxt    = CNT_W'(REDRAW_PERIOD);
          filled_nxt = FILL_W'(pos_r);
          if (full) begin
            wait_t = 1'b1;
            pos_t  = '0;
          end
        end else begin
          red_nxt = red_r - 1'b1;
        end
      end
      if (wait_t || pos_t == '0) begin
        if (ret_r == '0) begin
          wait_t  = 1'b0;
          pos_t   = PW'(1);
          ret_nxt = CNT_W'(RETRIGGER_PERIOD);
          // slot 0 clear waits until the burst has read the store
          if (sts.burst_hit) begin
            pend_nxt = 1'b1;
          end else begin
            we = 1'b1;
          end
        end else begin
          ret_nxt = ret_r - 1'b1;
        end
      end else begin
        ret_nxt = CNT_W'(RETRIGGER_PERIOD);
      end
      wait_nxt = wait_t;
      pos_nxt  = pos_t;
    end

    if (cmd.finish && pend_r) begin
      we       = 1'b1;
      pend_nxt = 1'b0;
    end
  end

  // Store array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // Registered store read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
      rbit_r  <= vld_r[rd_addr];
      rslot_r <= rd_addr;
      rlast_r <= (rd_addr == AW'(CAPTURE_DEPTH - 1));
    end
  end

  // Clamp to +/- limit
  always_comb begin
    logic signed [SAMPLE_W:0] v;
    logic signed [SAMPLE_W:0] hi;
    logic signed [SAMPLE_W:0] lo;
    v  = rbit_r ? {rdata_r[SAMPLE_W-1], rdata_r} : '0;
    hi = {2'b00, limit_r};
    lo = -hi;
    if (v > hi) begin
      clamp_val = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      clamp_val = lo[SAMPLE_W-1:0];
    end else begin
      clamp_val = v[SAMPLE_W-1:0];
    end
  end

  // Output register; fill count travels with the value so a new burst
  // cannot change a result that is still waiting
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_val_r  <= clamp_val;
      out_slot_r <= rslot_r;
      out_last_r <= rlast_r;
      out_fill_r <= filled_r;
    end
  end

  assign clamped_value = out_val_r;
  assign slot_index    = SLOT_W'(out_slot_r);
  assign filled_count  = out_fill_r;
  assign last_of_burst = out_last_r;

endmodule

[sim/tb_scope_trigger_capture_unit.sv]
module tb_scope_trigger_capture_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;

  localparam int CAP_DEPTH   = 64;
  localparam int REDRAW_PER  = 10;
  localparam int RETRIG_PER  = 10;
  // index 3 decodes to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // burst stall plus output pipeline, with margin
  localparam int SETTLE_CYCLES = CAP_DEPTH + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 5000;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic [SLOT_W-1:0]   slot;
    logic [FILL_W-1:0]   fill;
    logic                last;
  } readout_t;

  // Capture predictor and readout scoreboard
  class capture_scoreboard;
    readout_t readout_q[$];
    int errors;
    logic signed [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0]        decim;
    logic [LIMIT_W-1:0]         limit;
    int                         position;
    logic signed [SAMPLE_W-1:0] store [CAP_DEPTH];
    logic [SAMPLE_W-1:0]        dec_cnt;
    int                         redraw_cnt;
    int                         retrig_cnt;

    function new();
      errors     = 0;
      level      = RST_LEVEL;
      decim      = RST_DECIMATION;
      limit      = RST_LIMIT;
      position   = -1;
      foreach (store[i]) store[i] = '0;
      dec_cnt    = RST_DECIMATION;
      redraw_cnt = REDRAW_PER;
      retrig_cnt = RETRIG_PER;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function int pending();
      return readout_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TRIGGER_LEVEL: level = val;
        REG_DECIMATION:    decim = val;
        REG_CLAMP_LIMIT:   limit = val[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void fast_tick(logic signed [SAMPLE_W-1:0] s);
      // full store freezes the decimation counter too
      if (position >= CAP_DEPTH) return;
      if (dec_cnt != 0) begin
        dec_cnt--;
        return;
      end
      dec_cnt = decim;
      if (position < 0) begin
        if (s < 0) position = 0;
      end else if (position == 0) begin
        if (s > level) begin
          store[0] = s;
          position = 1;
        end
      end else begin
        store[position] = s;
        position++;
      end
    endfunction

    function void slow_tick();
      readout_t r;
      int v;
      int lim;
      // redraw countdown only runs while something is captured
      if (position > 0) begin
        if (redraw_cnt == 0) begin
          lim = limit;
          for (int i = 0; i < CAP_DEPTH; i++) begin
            v = store[i];
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            r.value = v[SAMPLE_W-1:0];
            r.slot  = i[SLOT_W-1:0];
            r.fill  = position[FILL_W-1:0];
            r.last  = (i == CAP_DEPTH - 1);
            readout_q.push_back(r);
          end
          redraw_cnt = REDRAW_PER;
          if (position >= CAP_DEPTH) position = -1;
        end else begin
          redraw_cnt--;
        end
      end
      // forced retrigger when no capture is running
      if (position <= 0) begin
        if (retrig_cnt == 0) begin
          store[0]   = '0;
          position   = 1;
          retrig_cnt = RETRIG_PER;
        end else begin
          retrig_cnt--;
        end
      end else begin
        retrig_cnt = RETRIG_PER;
      end
    endfunction

    function void note_input(logic op, logic [SAMPLE_W-1:0] s);
      if (op == OP_FAST) fast_tick(s);
      else slow_tick();
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      readout_t e;
      if (readout_q.size() == 0) begin
        report($sformatf("unexpected result tdata=%h tlast=%b", data, last));
        return;
      end
      e = readout_q.pop_front();
      if (data[15:0] !== e.value || data[21:16] !== e.slot || data[28:22] !== e.fill ||
          data[31:29] !== 3'b000 || last !== e.last)
        report($sformatf({"slot %0d: got val=%h slot=%0d fill=%0d pad=%b last=%b, ",
                          "exp val=%h fill=%0d last=%b"},
                         e.slot, data[15:0], data[21:16], data[28:22], data[31:29], last,
                         e.value, e.fill, e.last));
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  capture_scoreboard sb = new();

  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;
  int idle_cycles = 0;

  scope_trigger_capture_unit #(
    .CAPTURE_DEPTH   (CAP_DEPTH),
    .REDRAW_PERIOD   (REDRAW_PER),
    .RETRIGGER_PERIOD(RETRIG_PER)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Transaction monitors on both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser[0], in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_scope_trigger_capture_unit: FAIL");
      $finish;
    end
  end

  // Receiver: random gaps, steady stretches, one long hold-off
  initial begin
    int gap;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 10);
      if (!held && taken >= 100) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
      if (taken % CAP_DEPTH == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_item(logic op, logic [SAMPLE_W-1:0] s);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    sb.write_reg(idx, val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Let every expected readout drain, then give the block time to go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly arm / trigger / capture material, with slow ticks and noise mixed in
  task automatic run_random(int count);
    int r;
    int lo;
    logic [SAMPLE_W-1:0] s;
    for (int k = 0; k < count; k++) begin
      if (k % 30 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_item(OP_SLOW, 16'($urandom()));
      end else begin
        if (r < 45) begin
          s = {1'b1, 15'($urandom())};
        end else if (r < 70 && sb.level != 16'sh7fff) begin
          lo = int'(sb.level) + 1;
          s  = 16'($urandom_range(lo + 32768, 65535) - 32768);
        end else begin
          s = 16'($urandom());
        end
        send_item(OP_FAST, s);
      end
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] lvl, logic [CFG_DATA_W-1:0] dec,
                           logic [CFG_DATA_W-1:0] lim, int count);
    settle();
    cfg_write(REG_TRIGGER_LEVEL, lvl);
    cfg_write(REG_DECIMATION, dec);
    cfg_write(REG_CLAMP_LIMIT, lim);
    run_random(count);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] probe_samples [10];
    probe_samples = '{16'hffff, 16'h7fff, 16'h8000, 16'h0000, 16'd1000,
                      16'd1001, 16'hfc18, 16'hfc17, 16'h5555, 16'haaaa};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(REG_DECIMATION, 16'd0);
    cfg_write(REG_UNUSED, 16'($urandom()));

    // Directed: boundary samples while the reset decimation count runs down,
    // then slow ticks up to a forced capture and its first redraw
    foreach (probe_samples[i]) send_item(OP_FAST, probe_samples[i]);
    repeat (RETRIG_PER + REDRAW_PER + 2) send_item(OP_SLOW, 16'h0000);
    send_item(OP_FAST, 16'hffff);
    send_item(OP_SLOW, 16'hffff);

    // Extremes: lowest level with widest clamp, highest level with tightest nonzero clamp
    run_phase(16'h8000, 16'd0, 16'h7fff, 60);
    run_phase(16'h7fff, 16'd0, 16'd1, 60);
    // zero clamp; bit 15 of the write data falls outside the register
    run_phase(16'($urandom_range(0, 4000) - 2000), 16'd1, 16'h8000, 60);
    run_phase(16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 3)),
              16'($urandom_range(1, 32767)), 60);
    run_phase(16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 3)),
              16'($urandom_range(1, 32767)), 60);
    // widest decimation last: once reloaded it freezes sample keeping
    run_phase(16'($urandom()), 16'hffff, 16'($urandom_range(1, 32767)), 30);

    settle();
    if (sb.errors == 0) begin
      $display("tb_scope_trigger_capture_unit: PASS");
    end else begin
      $display("tb_scope_trigger_capture_unit: FAIL");
    end
    $finish;
  end

endmodule
